FILE: src/ccbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccbe_pkg;

    localparam int NumPix     = 8;
    localparam int PixWidth   = 4;
    localparam int NumColours = 16;
    localparam int CntWidth   = 4;
    localparam int InWidth    = NumPix * PixWidth;
    localparam int OutWidth   = 40;

    localparam logic [PixWidth-1:0] LowColourMax = 4'd7;

    typedef logic [PixWidth-1:0]             pix_t;
    typedef logic [NumPix-1:0][PixWidth-1:0] span_t;
    typedef logic [CntWidth-1:0]             cnt_t;

    typedef struct packed {
        span_t                 pix;
        logic [NumColours-1:0] used;
        pix_t                  fg;
        logic                  have_fg;
    } scan_t;

    typedef struct packed {
        span_t       pix;
        logic [7:0]  shape_first;
        logic [7:0]  attr_inverted;
        logic [7:0]  attr_nibbles;
        pix_t        top_b;
        pix_t        top_f;
    } pick_t;

    typedef struct packed {
        logic [7:0]  shape_second;
        pix_t        front_minor;
        pix_t        back_major;
        logic [7:0]  attr_nibbles;
        logic [7:0]  attr_inverted;
        logic [7:0]  shape_first;
    } result_t;

    function automatic logic [NumPix-1:0] match_mask(input span_t pix, input pix_t colour);
        logic [NumPix-1:0] m;
        m = '0;
        for (int k = 0; k < NumPix; k++)
        begin
            m[k] = (pix[k] == colour);
        end
        return m;
    endfunction

    function automatic cnt_t pop8(input logic [NumPix-1:0] m);
        cnt_t c;
        c = '0;
        for (int k = 0; k < NumPix; k++)
        begin
            c = c + cnt_t'(m[k]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/ccbe_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ccbe_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ccbe_pkg::span_t in_pix,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ccbe_pkg::scan_t     out_data
);
    import ccbe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    scan_t data_reg;
    scan_t data_next;

    always_comb
    begin
        data_next.pix     = in_pix;
        data_next.used    = '0;
        data_next.fg      = '0;
        data_next.have_fg = 1'b0;
        for (int k = 0; k < NumPix; k++)
        begin
            data_next.used[in_pix[k]] = 1'b1;
        end
        for (int k = 1; k < NumPix; k++)
        begin
            if (in_pix[k] != in_pix[0])
            begin
                data_next.fg      = in_pix[k];
                data_next.have_fg = 1'b1;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: src/ccbe_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module ccbe_pick (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ccbe_pkg::scan_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ccbe_pkg::pick_t      out_data
);
    import ccbe_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    pick_t                 data_reg;
    pick_t                 data_next;
    pix_t                  bg;
    pix_t                  fg;
    logic [NumColours-1:0] rest;

    always_comb
    begin
        bg = in_data.pix[0];
        fg = in_data.fg;
        data_next.pix           = in_data.pix;
        data_next.shape_first   = in_data.have_fg ? match_mask(in_data.pix, fg) : '0;
        data_next.attr_inverted = {(bg <= LowColourMax), (fg <= LowColourMax),
                                   fg[2:0], bg[2:0]};
        data_next.attr_nibbles  = {fg, bg};

        data_next.top_b = '0;
        for (int k = 0; k < NumColours; k++)
        begin
            if (in_data.used[k])
            begin
                data_next.top_b = pix_t'(k);
            end
        end
        rest = in_data.used;
        rest[data_next.top_b] = 1'b0;
        data_next.top_f = '0;
        for (int k = 0; k < NumColours; k++)
        begin
            if (rest[k])
            begin
                data_next.top_f = pix_t'(k);
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: src/ccbe_vote.sv
`timescale 1ns / 1ps
`default_nettype none

module ccbe_vote (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ccbe_pkg::pick_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ccbe_pkg::result_t    out_data
);
    import ccbe_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    result_t           data_reg;
    result_t           data_next;
    logic [NumPix-1:0] eq_b;
    logic [NumPix-1:0] eq_f;
    cnt_t              cnt_b;
    cnt_t              cnt_f;

    always_comb
    begin
        eq_b  = match_mask(in_data.pix, in_data.top_b);
        eq_f  = match_mask(in_data.pix, in_data.top_f);
        cnt_b = pop8(eq_b);
        cnt_f = pop8(eq_f);
        data_next.shape_first   = in_data.shape_first;
        data_next.attr_inverted = in_data.attr_inverted;
        data_next.attr_nibbles  = in_data.attr_nibbles;
        if (cnt_b > cnt_f)
        begin
            data_next.back_major   = in_data.top_b;
            data_next.front_minor  = in_data.top_f;
            data_next.shape_second = eq_f;
        end
        else
        begin
            data_next.back_major   = in_data.top_f;
            data_next.front_minor  = in_data.top_b;
            data_next.shape_second = eq_b;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: src/color_clash_block_encoder.sv
// Eight-pixel colour-clash block encoder.
// Slave stream s_axis carries one span of eight 4-bit palette indices per
// transaction; master stream m_axis returns one result transaction per span,
// holding the first-scheme shape and attribute bytes and the second-scheme
// back, front and shape.
// A span moves to m_axis through one register stage each for the colour scan,
// the colour pick and the majority vote.
// Throughput: one span per cycle while m_axis_tready stays high; every stage
// takes a new transaction in the cycle its own result moves on.
// A stall on m_axis_tready holds the last stage; earlier stages keep
// accepting until they are full, then s_axis_tready drops. Nothing is lost
// or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline; the block holds no
// other state.
`timescale 1ns / 1ps
`default_nettype none

module color_clash_block_encoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ccbe_pkg::InWidth-1:0]   s_axis_tdata,  // pix0..pix7, 4 bits each
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [ccbe_pkg::OutWidth-1:0]       m_axis_tdata   // shape_first, attr_inverted,
                                                               // attr_nibbles, back_major,
                                                               // front_minor, shape_second
);
    import ccbe_pkg::*;

    span_t   in_pix;
    scan_t   scan_data;
    pick_t   pick_data;
    result_t res;
    logic    scan_valid;
    logic    scan_ready;
    logic    pick_valid;
    logic    pick_ready;

    assign in_pix = span_t'(s_axis_tdata);

    ccbe_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .out_valid (scan_valid),
        .out_ready (scan_ready),
        .out_data  (scan_data)
    );

    ccbe_pick u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scan_valid),
        .in_ready  (scan_ready),
        .in_data   (scan_data),
        .out_valid (pick_valid),
        .out_ready (pick_ready),
        .out_data  (pick_data)
    );

    ccbe_vote u_vote (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pick_valid),
        .in_ready  (pick_ready),
        .in_data   (pick_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = OutWidth'(res);

    a_uniform_no_shape : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.attr_nibbles[7:4] == res.attr_nibbles[3:0])
        |-> res.shape_first == 8'h00)
        else $error("shape_first set with foreground equal to background");

    a_single_colour : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.back_major == res.front_minor)
        |-> res.front_minor == 4'd0 && res.shape_second == 8'hFF)
        else $error("second scheme back equals front on a mixed span");

    a_attr_agree : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid
        |-> res.attr_inverted[2:0] == res.attr_nibbles[2:0]
            && res.attr_inverted[7] == !res.attr_nibbles[3]
            && res.attr_inverted[6] == !res.attr_nibbles[7])
        else $error("attribute bytes disagree");

    a_drain : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

`default_nettype wire

FILE: verif/tb_color_clash_block_encoder.sv
`timescale 1ns / 1ps

module tb_color_clash_block_encoder;

    import ccbe_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 300;
    localparam int DrainWait  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    span_t       s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    result_t queued_encodings[$];
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    bit      hold_req = 1'b0;

    color_clash_block_encoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit)
        begin
            $display("color_clash_block_encoder verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] colour_mask(input span_t px, input pix_t colour);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < NumPix; k++)
        begin
            m[k] = (px[k] == colour);
        end
        return m;
    endfunction

    function automatic result_t encode_span(input span_t px);
        result_t    r;
        pix_t       bg;
        pix_t       fg;
        logic       have_fg;
        int         tally[NumColours];
        pix_t       top_b;
        pix_t       top_f;
        int         b_cnt;
        int         f_cnt;
        bg      = px[0];
        fg      = '0;
        have_fg = 1'b0;
        for (int k = 0; k < NumPix; k++)
        begin
            if (px[k] != bg)
            begin
                fg      = px[k];
                have_fg = 1'b1;
            end
        end
        r.shape_first   = have_fg ? colour_mask(px, fg) : 8'h00;
        r.attr_inverted = {bg <= LowColourMax, fg <= LowColourMax, fg[2:0], bg[2:0]};
        r.attr_nibbles  = {fg, bg};

        for (int c = 0; c < NumColours; c++)
        begin
            tally[c] = 0;
        end
        for (int k = 0; k < NumPix; k++)
        begin
            tally[px[k]]++;
        end
        top_b = '0;
        b_cnt = 0;
        top_f = '0;
        f_cnt = 0;
        for (int c = 0; c < NumColours; c++)
        begin
            if (tally[c] > 0)
            begin
                top_b = pix_t'(c);
                b_cnt = tally[c];
            end
        end
        for (int c = 0; c < NumColours; c++)
        begin
            if (tally[c] > 0 && pix_t'(c) != top_b)
            begin
                top_f = pix_t'(c);
                f_cnt = tally[c];
            end
        end
        if (b_cnt > f_cnt)
        begin
            r.back_major  = top_b;
            r.front_minor = top_f;
        end
        else
        begin
            r.back_major  = top_f;
            r.front_minor = top_b;
        end
        r.shape_second = colour_mask(px, r.front_minor);
        return r;
    endfunction

    function automatic span_t random_span();
        span_t px;
        pix_t  palette[3];
        int    mode;
        int    used;
        mode = $urandom_range(9);
        for (int i = 0; i < 3; i++)
        begin
            palette[i] = pix_t'($urandom_range(15));
        end
        used = $urandom_range(2, 3);
        for (int k = 0; k < NumPix; k++)
        begin
            case (mode)
                0, 1, 2: px[k] = pix_t'($urandom_range(15));
                8, 9:    px[k] = palette[0];
                default: px[k] = palette[$urandom_range(used - 1)];
            endcase
        end
        if (mode == 9)
        begin
            px[$urandom_range(NumPix - 1)] = palette[1];
        end
        return px;
    endfunction

    task automatic send_span(input span_t span);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= span;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        queued_encodings = {queued_encodings, encode_span(span)};
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (queued_encodings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainWait) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata);
            if (queued_encodings.size() == 0)
            begin
                $error("unexpected result transaction %010h", m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                want = queued_encodings.pop_front();
                compare_field("shape_first", want.shape_first, got.shape_first);
                compare_field("attr_inverted", want.attr_inverted, got.attr_inverted);
                compare_field("attr_nibbles", want.attr_nibbles, got.attr_nibbles);
                compare_field("back_major", want.back_major, got.back_major);
                compare_field("front_minor", want.front_minor, got.front_minor);
                compare_field("shape_second", want.shape_second, got.shape_second);
            end
        end
    end

    task automatic test_corner_spans();
        span_t corners[22] = '{
            32'h00000000, 32'hFFFFFFFF, 32'h77777777, 32'h88888888,
            32'h76543210, 32'h01234567, 32'hFEDCBA98, 32'h89ABCDEF,
            32'hF0F0F0F0, 32'h0F0F0F0F, 32'hFFFFFFF0, 32'h0000000F,
            32'h10000000, 32'h00000001, 32'hA5A5A5A5, 32'h5A5A5A5A,
            32'h87878787, 32'h33333338, 32'h83333333, 32'h12121213,
            32'h00000077, 32'hEEEEEEE0
        };
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (corners[i])
        begin
            send_span(corners[i]);
        end
        drain();
    endtask

    task automatic test_random_spans(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
        begin
            send_span(random_span());
        end
        drain();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (40)
        begin
            send_span(random_span());
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_spans();
        test_random_spans(700, 29, 47);
        test_output_stall();
        test_random_spans(700, 47, 29);
        test_random_spans(600, 0, 0);

        if (err_cnt == 0)
        begin
            $display("color_clash_block_encoder verification clean");
        end
        else
        begin
            $display("color_clash_block_encoder verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ccbe_pkg.sv
src/ccbe_scan.sv
src/ccbe_pick.sv
src/ccbe_vote.sv
src/color_clash_block_encoder.sv
verif/tb_color_clash_block_encoder.sv
